>>> rtl/pva_pkg.sv
// Shared types and constants for the polyphonic voice allocator.
// Item layouts on both channels plus the controller/datapath command and status groups.
// No dependencies.
`timescale 1ns / 1ps

package pva_pkg;

	// Configuration register
	localparam int          PDATA_W    = 32;
	localparam int          PADDR_W    = 2;
	localparam int          POLY_W     = 5;
	localparam logic [4:0]  POLY_RESET = 5'd16;
	localparam logic [PADDR_W-1:0] POLY_ADDR = '0;

	// Field widths
	localparam int KEY_W   = 7;
	localparam int VEL_W   = 7;
	localparam int VIDX_W  = 4;

	// Incoming note event
	typedef struct packed {
		logic              press;
		logic [KEY_W-1:0]  note_key;
		logic [VEL_W-1:0]  velocity;
	} in_item_t;

	// Event forwarded to one voice
	typedef struct packed {
		logic [VIDX_W-1:0] voice_index;
		logic              gate_on;
		logic [KEY_W-1:0]  note_out;
		logic [VEL_W-1:0]  velocity_out;
		logic              voice_stolen;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic lookup;
		logic commit;
		logic clear;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic act;
	} ctrl_sts_t;

endpackage

>>> rtl/pva_ctrl.sv
// Sequencing controller for the voice allocator: idle, lookup, commit.
// Uses pva_pkg command and status types.
`timescale 1ns / 1ps

module pva_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               cfg_wr,
	input  pva_pkg::ctrl_sts_t sts,
	output pva_pkg::ctrl_cmd_t cmd,
	output logic               busy,
	output logic               strobe
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   strobe_q;

	// Decode commands from the current state
	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && start;
		cmd.lookup  = (state_q == ST_LOOKUP);
		cmd.commit  = (state_q == ST_COMMIT);
		cmd.clear   = cfg_wr;
	end

	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;

	// Advance state; flag a result when the commit produced one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_LOOKUP;
				end
				ST_LOOKUP: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					strobe_q <= sts.act;
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/pva_datapath.sv
// Voice state and allocation datapath: parallel note match, free-voice search,
// age ranks for oldest-voice stealing, and the result register. Uses pva_pkg.
`timescale 1ns / 1ps

module pva_datapath #(
	parameter int MAX_VOICES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pva_pkg::ctrl_cmd_t                cmd,
	output pva_pkg::ctrl_sts_t                sts,
	input  pva_pkg::in_item_t                 cmd_item,
	input  logic [$clog2(MAX_VOICES+1)-1:0]   active,
	output pva_pkg::out_item_t                result
);

	localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
	localparam int CW = $clog2(MAX_VOICES+1);

	pva_pkg::in_item_t               item_q;
	logic [MAX_VOICES-1:0]           busy_q;
	logic [pva_pkg::KEY_W-1:0]       note_q [MAX_VOICES];
	logic [VW-1:0]                   rank_q [MAX_VOICES];
	logic [CW-1:0]                   count_q;

	logic [MAX_VOICES-1:0]           sel_oh_s1;
	logic [VW-1:0]                   sel_idx_s1;
	logic [VW-1:0]                   hit_rank_s1;
	logic                            stolen_s1;
	logic                            act_s1;
	pva_pkg::out_item_t              result_q;

	logic [MAX_VOICES-1:0]           hit_vec, free_vec, old_vec, free_oh;
	logic [VW-1:0]                   hit_idx, free_idx, old_idx, hit_rank;
	logic                            free_any, hit_any;
	logic [CW-1:0]                   oldest_rank;
	logic [VW+pva_pkg::VIDX_W-1:0]   vidx_ext;

	// Match, free and oldest vectors over all voices
	assign oldest_rank = count_q - CW'(1);

	always_comb begin
		hit_vec  = '0;
		free_vec = '0;
		old_vec  = '0;
		hit_idx  = '0;
		old_idx  = '0;
		hit_rank = '0;
		for (int v = 0; v < MAX_VOICES; v++) begin
			hit_vec[v]  = busy_q[v] && (note_q[v] == item_q.note_key);
			free_vec[v] = !busy_q[v] && (CW'(v) < active);
			old_vec[v]  = busy_q[v] && (CW'(rank_q[v]) == oldest_rank);
			if (hit_vec[v]) begin
				hit_idx  = hit_idx | VW'(v);
				hit_rank = hit_rank | rank_q[v];
			end
			if (old_vec[v]) old_idx = old_idx | VW'(v);
		end
	end

	// Lowest-numbered free voice
	always_comb begin
		free_oh  = '0;
		free_idx = '0;
		for (int v = MAX_VOICES - 1; v >= 0; v--) begin
			if (free_vec[v]) begin
				free_oh      = '0;
				free_oh[v]   = 1'b1;
				free_idx     = VW'(v);
			end
		end
	end

	assign free_any = |free_vec;
	assign hit_any  = |hit_vec;

	// Capture the item and register the lookup decision
	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= cmd_item;
		if (cmd.lookup) begin
			hit_rank_s1 <= hit_rank;
			if (item_q.press) begin
				sel_oh_s1  <= free_any ? free_oh : old_vec;
				sel_idx_s1 <= free_any ? free_idx : old_idx;
				stolen_s1  <= !free_any;
			end else begin
				sel_oh_s1  <= hit_vec;
				sel_idx_s1 <= hit_idx;
				stolen_s1  <= 1'b0;
			end
		end
	end

	// Result goes out only for a new note on or a release of a held note
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
		end else if (cmd.lookup) begin
			act_s1 <= item_q.press ? !hit_any : hit_any;
		end
	end

	assign sts.act = act_s1;

	// Apply the allocation: busy flags and count; a polyphony write clears both
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= '0;
			count_q <= '0;
		end else if (cmd.clear) begin
			busy_q  <= '0;
			count_q <= '0;
		end else if (cmd.commit && act_s1) begin
			if (item_q.press) begin
				busy_q <= busy_q | sel_oh_s1;
				if (!stolen_s1) count_q <= count_q + CW'(1);
			end else begin
				busy_q  <= busy_q & ~sel_oh_s1;
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Notes and age ranks: newest is rank 0, oldest is count-1
	always_ff @(posedge clk) begin
		if (cmd.commit && act_s1) begin
			for (int v = 0; v < MAX_VOICES; v++) begin
				if (item_q.press) begin
					if (sel_oh_s1[v]) begin
						note_q[v] <= item_q.note_key;
						rank_q[v] <= '0;
					end else if (busy_q[v]) begin
						rank_q[v] <= rank_q[v] + VW'(1);
					end
				end else if (!sel_oh_s1[v] && busy_q[v] && (rank_q[v] > hit_rank_s1)) begin
					rank_q[v] <= rank_q[v] - VW'(1);
				end
			end
		end
	end

	// Hold the forwarded event for the result cycle
	assign vidx_ext = {{pva_pkg::VIDX_W{1'b0}}, sel_idx_s1};

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			result_q.voice_index  <= vidx_ext[pva_pkg::VIDX_W-1:0];
			result_q.gate_on      <= item_q.press;
			result_q.note_out     <= item_q.note_key;
			result_q.velocity_out <= item_q.velocity;
			result_q.voice_stolen <= stolen_s1;
		end
	end

	assign result = result_q;

endmodule

>>> rtl/poly_voice_allocator.sv
// Polyphonic voice allocator with oldest-voice stealing.
// A new item is taken only in idle: busy covers the lookup and commit cycles after acceptance.
// A result, if any, is strobed for one cycle once the commit state has ended;
// the next item is accepted at the edge that ends it, and results cannot be held off.
// The search over all voices fills the lookup cycle and the commit cycle updates state.
// Reset clears all voices and sets polyphony to 16; a polyphony write clears all voices.
`timescale 1ns / 1ps

module poly_voice_allocator #(
	parameter int MAX_VOICES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  pva_pkg::in_item_t               cmd_item,
	output logic                            strobe,
	output pva_pkg::out_item_t              result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pva_pkg::PADDR_W-1:0]     paddr,
	input  logic [pva_pkg::PDATA_W-1:0]     pwdata,
	output logic [pva_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready
);

	localparam int           CW      = $clog2(MAX_VOICES+1);
	localparam logic [CW-1:0] ACT_RST = CW'((MAX_VOICES < 16) ? MAX_VOICES : 16);

	logic [pva_pkg::POLY_W-1:0] poly_q;
	logic [CW-1:0]              active_q;
	logic [CW-1:0]              active_d;
	logic [pva_pkg::POLY_W-1:0] poly_d;
	logic                       cfg_wr;
	pva_pkg::ctrl_cmd_t         cmd;
	pva_pkg::ctrl_sts_t         sts;

	// Single register: decode polyphony at its address
	assign pready      = 1'b1;
	assign cfg_wr      = psel && penable && pwrite && pready && (paddr == pva_pkg::POLY_ADDR);
	assign poly_d      = pwdata[pva_pkg::POLY_W-1:0];
	assign prdata      = {{(pva_pkg::PDATA_W-pva_pkg::POLY_W){1'b0}}, poly_q};

	// Clamp the voice count to one through MAX_VOICES
	always_comb begin
		if (poly_d == '0) begin
			active_d = CW'(1);
		end else if (int'(poly_d) > MAX_VOICES) begin
			active_d = CW'(MAX_VOICES);
		end else begin
			active_d = CW'(poly_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q   <= pva_pkg::POLY_RESET;
			active_q <= ACT_RST;
		end else if (cfg_wr) begin
			poly_q   <= poly_d;
			active_q <= active_d;
		end
	end

	pva_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cfg_wr (cfg_wr),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.strobe (strobe)
	);

	pva_datapath #(
		.MAX_VOICES (MAX_VOICES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.cmd_item (cmd_item),
		.active   (active_q),
		.result   (result)
	);

	// An accepted item always starts the lookup sequence
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	// A result only follows a commit cycle
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result strobe without preceding work");

	// A forwarded note off never reports a steal
	a_off_not_stolen: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.gate_on) |-> !result.voice_stolen)
		else $error("note off flagged as stolen");

	// Results are single-cycle strobes
	a_strobe_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("result strobe held longer than one cycle");

endmodule
